// File: sv/pdkv_pkg.sv
// ----------------------------------------------------------------------------
// pdkv_pkg
// Shared types, sizes and helpers of the pinned/dirty key-value table.
// ----------------------------------------------------------------------------
package pdkv_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned VALUE_BYTES = 8;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);
  localparam logic [3:0]       KEY_LIM    = 4'(KEY_BYTES);
  localparam logic [3:0]       VAL_LIM    = 4'(VALUE_BYTES);

  typedef enum logic [2:0] {
    FN_SEARCH = 3'd0,
    FN_UPDATE = 3'd1,
    FN_DELETE = 3'd2,
    FN_SETPIN = 3'd3,
    FN_DROP   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_KEPT      = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_MAX_KEY = 1'b0,
    CFG_MAX_VAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_COMPACT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  klen;
    logic [63:0] value;
    logic [3:0]  vlen;
    logic        dirty;
    logic        pinned;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan_step;
    logic act;
    logic cmp_step;
    logic cmp_fin;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       scan_done;
    logic       found;
    logic       cmp_done;
    logic       out_free;
  } sts_t;

  // ones in the low n bytes of a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int b = 0; b < 8; b++) begin
      m[8*b +: 8] = {8{4'(b) < n}};
    end
    return m;
  endfunction

endpackage

// File: sv/pinned_dirty_key_value_table.sv
// ----------------------------------------------------------------------------
// pinned_dirty_key_value_table
// Insertion-ordered key/value table with dirty and pinned flags per entry.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// cmd      in         in_valid_i/in_stall_o  func, key, key_len, value, ...
// result   out        out_valid_o/out_stall_i status, found_value, ... counts
// config   in         cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// one command at a time: capture, then scan (no key walk for drop), then act, then finish;
// drop, and a delete that finds its key, add a compaction walk before finish.
// the slot walk goes through a single read port of the slot store.
// reset empties the table at once; slot contents stay undefined.
// a stalled result holds in the output register; the next command is taken
// while it waits and finishes only once the register frees.
module pinned_dirty_key_value_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdkv_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [3:0]                     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     func_i,
  input  logic [63:0]                    key_i,
  input  logic [3:0]                     key_len_i,
  input  logic [63:0]                    value_i,
  input  logic [3:0]                     value_len_i,
  input  logic                           keep_i,
  input  logic                           mark_dirty_i,
  input  logic                           pin_i,
  input  logic                           pin_state_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [63:0]                    found_value_o,
  output logic [3:0]                     found_value_len_o,
  output logic                           entry_dirty_o,
  output logic                           entry_pinned_o,
  output logic                           page_dirty_out_o,
  output logic                           page_pinned_out_o,
  output logic [4:0]                     count_out_o,
  output logic [4:0]                     dropped_count_o
);

  pdkv_pkg::cmd_t cmd;
  pdkv_pkg::sts_t sts;

  // sequencer
  pdkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and datapath
  pdkv_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .func_i            (func_i),
    .key_i             (key_i),
    .key_len_i         (key_len_i),
    .value_i           (value_i),
    .value_len_i       (value_len_i),
    .keep_i            (keep_i),
    .mark_dirty_i      (mark_dirty_i),
    .pin_i             (pin_i),
    .pin_state_i       (pin_state_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .found_value_o     (found_value_o),
    .found_value_len_o (found_value_len_o),
    .entry_dirty_o     (entry_dirty_o),
    .entry_pinned_o    (entry_pinned_o),
    .page_dirty_out_o  (page_dirty_out_o),
    .page_pinned_out_o (page_pinned_out_o),
    .count_out_o       (count_out_o),
    .dropped_count_o   (dropped_count_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

// File: sv/pdkv_ctrl.sv
// ----------------------------------------------------------------------------
// pdkv_ctrl
// Command sequencer: scan, act, compact and result hand-off.
// ----------------------------------------------------------------------------
module pdkv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pdkv_pkg::sts_t sts_i,
  output pdkv_pkg::cmd_t cmd_o
);

  pdkv_pkg::state_e state_q, state_d;
  logic             go_compact;

  assign go_compact = (sts_i.func == pdkv_pkg::FN_DROP) ||
                      ((sts_i.func == pdkv_pkg::FN_DELETE) && sts_i.found);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdkv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdkv_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pdkv_pkg::S_SCAN;
      end
      pdkv_pkg::S_SCAN: begin
        if (sts_i.scan_done) state_d = pdkv_pkg::S_ACT;
      end
      pdkv_pkg::S_ACT: begin
        state_d = go_compact ? pdkv_pkg::S_COMPACT : pdkv_pkg::S_FINISH;
      end
      pdkv_pkg::S_COMPACT: begin
        if (sts_i.cmp_done) state_d = pdkv_pkg::S_FINISH;
      end
      pdkv_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = pdkv_pkg::S_IDLE;
      end
      default: state_d = pdkv_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != pdkv_pkg::S_IDLE);
    unique case (state_q)
      pdkv_pkg::S_IDLE:    cmd_o.latch     = in_valid_i;
      pdkv_pkg::S_SCAN:    cmd_o.scan_step = !sts_i.scan_done;
      pdkv_pkg::S_ACT:     cmd_o.act       = 1'b1;
      pdkv_pkg::S_COMPACT: begin
        cmd_o.cmp_step = !sts_i.cmp_done;
        cmd_o.cmp_fin  = sts_i.cmp_done;
      end
      pdkv_pkg::S_FINISH:  cmd_o.load_out  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/pdkv_dp.sv
// ----------------------------------------------------------------------------
// pdkv_dp
// Slot storage, key compare, update logic, compaction pointers and result
// register.
// ----------------------------------------------------------------------------
module pdkv_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pdkv_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [3:0]                        cfg_wdata_i,
  input  logic [2:0]                        func_i,
  input  logic [63:0]                       key_i,
  input  logic [3:0]                        key_len_i,
  input  logic [63:0]                       value_i,
  input  logic [3:0]                        value_len_i,
  input  logic                              keep_i,
  input  logic                              mark_dirty_i,
  input  logic                              pin_i,
  input  logic                              pin_state_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [2:0]                        status_o,
  output logic [63:0]                       found_value_o,
  output logic [3:0]                        found_value_len_o,
  output logic                              entry_dirty_o,
  output logic                              entry_pinned_o,
  output logic                              page_dirty_out_o,
  output logic                              page_pinned_out_o,
  output logic [4:0]                        count_out_o,
  output logic [4:0]                        dropped_count_o,
  input  pdkv_pkg::cmd_t                    cmd_i,
  output pdkv_pkg::sts_t                    sts_o
);

  localparam int unsigned IW = pdkv_pkg::IDX_W;
  localparam int unsigned CW = pdkv_pkg::CNT_W;

  pdkv_pkg::slot_t slot_q [pdkv_pkg::ENTRIES];

  logic [3:0]    max_key_q, max_val_q;
  logic [2:0]    func_q;
  logic [63:0]   key_q, value_q;
  logic [3:0]    klen_q, vlen_q;
  logic          keep_q, mdirty_q, pin_q, pstate_q;
  logic [CW-1:0] count_q, scan_q, rd_ptr_q, wr_ptr_q, dropped_q;
  logic [IW-1:0] midx_q;
  logic          found_q, any_q;
  logic          page_dirty_q, page_pinned_q;
  logic [2:0]    res_status_q;
  pdkv_pkg::slot_t res_slot_q;
  logic          out_valid_q;

  logic [3:0]      klim, vlim;
  logic            klen_ok;
  logic [IW-1:0]   rd_idx;
  pdkv_pkg::slot_t rd;
  logic            hit, first_hit;
  logic            we;
  logic [IW-1:0]   wa;
  pdkv_pkg::slot_t wd;
  logic            skip;

  assign klim    = (max_key_q < pdkv_pkg::KEY_LIM) ? max_key_q : pdkv_pkg::KEY_LIM;
  assign vlim    = (max_val_q < pdkv_pkg::VAL_LIM) ? max_val_q : pdkv_pkg::VAL_LIM;
  assign klen_ok = (klen_q != 4'd0) && (klen_q <= klim);

  // single read port: scan index, compaction source or matched slot
  always_comb begin
    if (cmd_i.scan_step)     rd_idx = scan_q[IW-1:0];
    else if (cmd_i.cmp_step) rd_idx = rd_ptr_q[IW-1:0];
    else                     rd_idx = midx_q;
  end
  assign rd = slot_q[rd_idx];

  assign hit       = klen_ok && (rd.klen == klen_q) && (rd.key == key_q);
  assign first_hit = hit && !found_q;
  assign skip      = (func_q == pdkv_pkg::FN_DROP) && rd.pinned;

  // write port and act-phase result
  pdkv_pkg::status_e act_status;
  always_comb begin
    we         = 1'b0;
    wa         = midx_q;
    wd         = rd;
    act_status = pdkv_pkg::ST_NOT_FOUND;
    if (cmd_i.act) begin
      case (func_q)
        pdkv_pkg::FN_SEARCH: if (found_q) act_status = pdkv_pkg::ST_OK;
        pdkv_pkg::FN_UPDATE: begin
          if (klen_ok) begin
            if (found_q && keep_q) begin
              act_status = pdkv_pkg::ST_KEPT;
            end else if (vlen_q > vlim) begin
              act_status = pdkv_pkg::ST_TOO_LONG;
            end else if (!found_q && (count_q == pdkv_pkg::FULL_COUNT)) begin
              act_status = pdkv_pkg::ST_FULL;
            end else begin
              act_status = pdkv_pkg::ST_OK;
              we         = 1'b1;
              wa         = found_q ? midx_q : count_q[IW-1:0];
              wd.key     = key_q;
              wd.klen    = klen_q;
              wd.value   = value_q;
              wd.vlen    = vlen_q;
              wd.dirty   = (found_q & rd.dirty) | mdirty_q;
              wd.pinned  = (found_q & rd.pinned) | pin_q;
            end
          end
        end
        pdkv_pkg::FN_DELETE: if (found_q) act_status = pdkv_pkg::ST_OK;
        pdkv_pkg::FN_SETPIN: begin
          if (found_q) begin
            act_status = pdkv_pkg::ST_OK;
            we         = 1'b1;
            wd.pinned  = pstate_q;
          end
        end
        pdkv_pkg::FN_DROP:   act_status = pdkv_pkg::ST_OK;
        default: ;
      endcase
    end else if (cmd_i.cmp_step && !skip) begin
      we = 1'b1;
      wa = wr_ptr_q[IW-1:0];
      wd = rd;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (we) slot_q[wa] <= wd;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_key_q <= 4'd8;
      max_val_q <= 4'd8;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pdkv_pkg::CFG_MAX_KEY: max_key_q <= cfg_wdata_i;
        pdkv_pkg::CFG_MAX_VAL: max_val_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= func_i;
      key_q    <= key_i & pdkv_pkg::byte_mask(key_len_i);
      klen_q   <= key_len_i;
      value_q  <= value_i & pdkv_pkg::byte_mask(value_len_i);
      vlen_q   <= value_len_i;
      keep_q   <= keep_i;
      mdirty_q <= mark_dirty_i;
      pin_q    <= pin_i;
      pstate_q <= pin_state_i;
    end
  end

  // scan, match and compaction pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      scan_q    <= '0;
      found_q   <= 1'b0;
      any_q     <= 1'b0;
      midx_q    <= '0;
      dropped_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + 1'b1;
      any_q  <= any_q | (first_hit ? pstate_q : rd.pinned);
      if (first_hit) begin
        found_q <= 1'b1;
        midx_q  <= scan_q[IW-1:0];
      end
    end else if (cmd_i.act) begin
      res_status_q <= act_status;
      res_slot_q   <= ((func_q == pdkv_pkg::FN_SEARCH) && found_q) ? rd : '0;
      if (func_q == pdkv_pkg::FN_DROP) begin
        rd_ptr_q <= '0;
        wr_ptr_q <= '0;
      end else begin
        rd_ptr_q <= CW'(midx_q) + 1'b1;
        wr_ptr_q <= CW'(midx_q);
      end
    end else if (cmd_i.cmp_step) begin
      rd_ptr_q <= rd_ptr_q + 1'b1;
      if (skip) dropped_q <= dropped_q + 1'b1;
      else      wr_ptr_q  <= wr_ptr_q + 1'b1;
    end
  end

  // count and page flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      page_dirty_q  <= 1'b0;
      page_pinned_q <= 1'b0;
    end else if (cmd_i.act) begin
      if (func_q == pdkv_pkg::FN_SETPIN) page_pinned_q <= any_q;
      if ((func_q == pdkv_pkg::FN_UPDATE) && we) begin
        if (!found_q) count_q <= count_q + 1'b1;
        if (mdirty_q) page_dirty_q  <= 1'b1;
        if (pin_q)    page_pinned_q <= 1'b1;
      end
    end else if (cmd_i.cmp_fin) begin
      count_q <= wr_ptr_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o          <= res_status_q;
      found_value_o     <= res_slot_q.value;
      found_value_len_o <= res_slot_q.vlen;
      entry_dirty_o     <= res_slot_q.dirty;
      entry_pinned_o    <= res_slot_q.pinned;
      page_dirty_out_o  <= page_dirty_q;
      page_pinned_out_o <= page_pinned_q;
      count_out_o       <= 5'(count_q);
      dropped_count_o   <= 5'(dropped_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.func      = func_q;
  assign sts_o.scan_done = (func_q == pdkv_pkg::FN_DROP) || (scan_q == count_q);
  assign sts_o.found     = found_q;
  assign sts_o.cmp_done  = (rd_ptr_q >= count_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule
